@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the battery monitor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BMS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BMS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bms_pkg.sv @@
// ----------------------------------------------------------------------------
// bms_pkg
// Types, codes and constants of the battery monitor and sleep timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bms_pkg;

    localparam int OP_W    = 2;
    localparam int PIN_W   = 12;
    localparam int MV_W    = 14;
    localparam int TH_W    = 13;
    localparam int TICK_W  = 16;
    localparam int PCT_W   = 7;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 16;

    localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
    localparam logic [OP_W-1:0] OP_REFRESH = 2'd1;
    localparam logic [OP_W-1:0] OP_WAKE    = 2'd2;

    localparam logic [IDX_W-1:0] REG_SLEEP_TICKS = 2'd0;
    localparam logic [IDX_W-1:0] REG_LOW_TH      = 2'd1;
    localparam logic [IDX_W-1:0] REG_RESTORE_TH  = 2'd2;

    localparam logic [TICK_W-1:0] SLEEP_TICKS_RST = 16'd20;
    localparam logic [TH_W-1:0]   LOW_TH_RST      = 13'd3600;
    localparam logic [TH_W-1:0]   RESTORE_TH_RST  = 13'd3700;

    localparam logic [TICK_W-1:0] IDLE_MAX = 16'hFFFF;
    localparam logic [MV_W-1:0]   MV_MAX   = 14'd8599;

    // pin/10 = (pin * 52429) >> 19, exact for 16-bit operands
    localparam logic [27:0] DIV10_MUL = 28'd52429;
    localparam int          DIV10_SH  = 19;
    // x/6 = (x * 43691) >> 18, exact for 16-bit operands
    localparam logic [25:0] DIV6_MUL  = 26'd43691;
    localparam int          DIV6_SH   = 18;
    // (v - low) at or above this span clamps to full charge unless low mode is active
    localparam logic [MV_W-1:0]  PCT_SPAN = 14'd600;
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    typedef struct packed {
        logic [TICK_W-1:0] sleep_ticks;
        logic [TH_W-1:0]   low_threshold_mv;
        logic [TH_W-1:0]   restore_threshold_mv;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic [MV_W-1:0] mv;
        logic            charging_n;
    } stage_t;

    typedef struct packed {
        logic [MV_W-1:0]  battery_mv;
        logic [PCT_W-1:0] battery_percent;
        logic             low_mode;
        logic             sleeping;
        logic             display_enable;
        logic             display_flash;
        logic             radio_force_off;
        logic             restart;
        logic             charging;
    } res_t;

endpackage

@@ src/bms_item_if.sv @@
// ----------------------------------------------------------------------------
// bms_item_if
// Input item channel: operation, pin voltage and charger status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bms_item_if
    import bms_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [PIN_W-1:0] pin_mv;
    logic             charging_n;

    modport source (output valid, operation, pin_mv, charging_n, input ready);
    modport sink   (input valid, operation, pin_mv, charging_n, output ready);
endinterface

@@ src/bms_result_if.sv @@
// ----------------------------------------------------------------------------
// bms_result_if
// Result item channel: battery level, mode flags and event pulses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bms_result_if
    import bms_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [MV_W-1:0]  battery_mv;
    logic [PCT_W-1:0] battery_percent;
    logic             low_mode;
    logic             sleeping;
    logic             display_enable;
    logic             display_flash;
    logic             radio_force_off;
    logic             restart;
    logic             charging;

    modport source (
        output valid, battery_mv, battery_percent, low_mode, sleeping,
               display_enable, display_flash, radio_force_off, restart, charging,
        input  ready
    );
    modport sink (
        input  valid, battery_mv, battery_percent, low_mode, sleeping,
               display_enable, display_flash, radio_force_off, restart, charging,
        output ready
    );
endinterface

@@ src/bms_cfg_if.sv @@
// ----------------------------------------------------------------------------
// bms_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bms_cfg_if
    import bms_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/bms_cfg.sv @@
// ----------------------------------------------------------------------------
// bms_cfg
// Configuration register file: sleep ticks and the two voltage thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bms_cfg
    import bms_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    bms_cfg_if.sink       cfg,
    output cfg_t          cfg_val
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_val   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_SLEEP_TICKS: cfg_next.sleep_ticks          = cfg.data;
                REG_LOW_TH:      cfg_next.low_threshold_mv     = cfg.data[TH_W-1:0];
                REG_RESTORE_TH:  cfg_next.restore_threshold_mv = cfg.data[TH_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sleep_ticks          <= SLEEP_TICKS_RST;
            cfg_reg.low_threshold_mv     <= LOW_TH_RST;
            cfg_reg.restore_threshold_mv <= RESTORE_TH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/bms_in_stage.sv @@
// ----------------------------------------------------------------------------
// bms_in_stage
// Input register; scales pin millivolts to battery millivolts on the way in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bms_in_stage
    import bms_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    bms_item_if.sink item,
    input  logic     take,
    output logic     stage_valid,
    output stage_t   stage_item
);

    `include "assert_macros.svh"

    logic        valid_reg;
    logic        valid_next;
    stage_t      stage_reg;
    logic        accept;
    logic [27:0] tenth_prod;
    logic [8:0]  tenth;
    logic [MV_W-1:0] mv;

    // floor(pin*21/10) = 2*pin + floor(pin/10)
    assign tenth_prod = {16'd0, item.pin_mv} * DIV10_MUL;
    assign tenth      = tenth_prod[DIV10_SH+8:DIV10_SH];
    assign mv         = {1'b0, item.pin_mv, 1'b0} + {5'd0, tenth};

    assign item.ready  = !valid_reg || take;
    assign accept      = item.valid && item.ready;
    assign stage_valid = valid_reg;
    assign stage_item  = stage_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.operation  <= item.operation;
            stage_reg.mv         <= mv;
            stage_reg.charging_n <= item.charging_n;
        end
    end

    `BMS_ASSERT_IMP(a_mv_range, clk, rst_n, valid_reg, stage_reg.mv <= MV_MAX, "scaled mv out of range")

endmodule

@@ src/bms_ctrl.sv @@
// ----------------------------------------------------------------------------
// bms_ctrl
// Supervisor state, percent computation and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bms_ctrl
    import bms_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg_val,
    input  logic         stage_valid,
    input  stage_t       stage_item,
    output logic         take,
    bms_result_if.source result
);

    `include "assert_macros.svh"

    logic              low_reg,   low_next;
    logic              sleep_reg, sleep_next;
    logic              disp_reg,  disp_next;
    logic [TICK_W-1:0] idle_reg,  idle_next;
    logic [MV_W-1:0]   mv_reg,    mv_next;
    logic [PCT_W-1:0]  pct_reg,   pct_next;
    logic              out_valid_reg, out_valid_next;
    res_t              res_reg,   res_next;

    logic [MV_W-1:0]   v;
    logic [MV_W-1:0]   low_th;
    logic [MV_W-1:0]   restore_th;
    logic [MV_W-1:0]   diff;
    logic [25:0]       quot_prod;
    logic [PCT_W-1:0]  quot;
    logic [TICK_W-1:0] idle_inc;
    logic              flash, radio_off, restart;

    assign v          = stage_item.mv;
    assign low_th     = {1'b0, cfg_val.low_threshold_mv};
    assign restore_th = {1'b0, cfg_val.restore_threshold_mv};
    assign diff       = v - low_th;
    assign quot_prod  = {16'd0, diff[9:0]} * DIV6_MUL;
    assign quot       = quot_prod[DIV6_SH+PCT_W-1:DIV6_SH];
    assign idle_inc   = (idle_reg == IDLE_MAX) ? IDLE_MAX : idle_reg + 16'd1;

    assign take = stage_valid && (!out_valid_reg || result.ready);

    always_comb
    begin
        low_next   = low_reg;
        sleep_next = sleep_reg;
        disp_next  = disp_reg;
        idle_next  = idle_reg;
        mv_next    = mv_reg;
        pct_next   = pct_reg;
        flash      = 1'b0;
        radio_off  = 1'b0;
        restart    = 1'b0;
        case (stage_item.operation)
            OP_SAMPLE:
            begin
                if (!low_reg && v <= low_th)
                begin
                    low_next   = 1'b1;
                    sleep_next = 1'b1;
                    disp_next  = 1'b0;
                    radio_off  = 1'b1;
                end
                else if (low_reg && v >= restore_th)
                begin
                    low_next   = 1'b0;
                    sleep_next = 1'b0;
                    disp_next  = 1'b0;
                    idle_next  = '0;
                    restart    = 1'b1;
                end
                mv_next = v;
                if (low_next || v < low_th)
                begin
                    pct_next = '0;
                end
                else if (diff >= PCT_SPAN)
                begin
                    pct_next = PCT_FULL;
                end
                else
                begin
                    pct_next = quot;
                end
                if (!restart && !sleep_next && !low_next)
                begin
                    idle_next = idle_inc;
                    if (idle_inc == cfg_val.sleep_ticks)
                    begin
                        sleep_next = 1'b1;
                        disp_next  = 1'b0;
                    end
                end
            end
            OP_REFRESH:
            begin
                idle_next = '0;
            end
            OP_WAKE:
            begin
                if (!low_reg)
                begin
                    sleep_next = 1'b0;
                    idle_next  = '0;
                    disp_next  = 1'b1;
                end
                else
                begin
                    flash     = 1'b1;
                    disp_next = 1'b0;
                end
            end
            default:
            begin
                idle_next = idle_reg;
            end
        endcase
    end

    always_comb
    begin
        res_next.battery_mv      = mv_next;
        res_next.battery_percent = pct_next;
        res_next.low_mode        = low_next;
        res_next.sleeping        = sleep_next;
        res_next.display_enable  = disp_next;
        res_next.display_flash   = flash;
        res_next.radio_force_off = radio_off;
        res_next.restart         = restart;
        res_next.charging        = !stage_item.charging_n;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg       <= 1'b0;
            sleep_reg     <= 1'b0;
            disp_reg      <= 1'b0;
            idle_reg      <= '0;
            mv_reg        <= '0;
            pct_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                low_reg   <= low_next;
                sleep_reg <= sleep_next;
                disp_reg  <= disp_next;
                idle_reg  <= idle_next;
                mv_reg    <= mv_next;
                pct_reg   <= pct_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.battery_mv      = res_reg.battery_mv;
    assign result.battery_percent = res_reg.battery_percent;
    assign result.low_mode        = res_reg.low_mode;
    assign result.sleeping        = res_reg.sleeping;
    assign result.display_enable  = res_reg.display_enable;
    assign result.display_flash   = res_reg.display_flash;
    assign result.radio_force_off = res_reg.radio_force_off;
    assign result.restart         = res_reg.restart;
    assign result.charging        = res_reg.charging;

    `BMS_ASSERT_IMP(a_low_sleeps, clk, rst_n, low_reg, sleep_reg, "low mode without sleep")
    `BMS_ASSERT_IMP(a_low_dark, clk, rst_n, low_reg, !disp_reg, "display on in low mode")
    `BMS_ASSERT_NXT(a_restart_clear, clk, rst_n, take && restart, !low_reg && idle_reg == '0 && !out_valid_reg == 1'b0, "restart did not clear state")
    `BMS_ASSERT_IMP(a_pct_range, clk, rst_n, out_valid_reg, res_reg.battery_percent <= PCT_FULL, "percent above full")

endmodule

@@ src/battery_monitor_sleep_timer.sv @@
// ----------------------------------------------------------------------------
// battery_monitor_sleep_timer
// Battery supervisor with low-battery hysteresis and an inactivity sleep timer.
//
// Channels: item (operation, pin_mv, charging_n), result (one item out for
// every item in), cfg (register writes: sleep_ticks, low and restore
// thresholds; always ready, write only while no item is in flight).
// Path: an accepted item passes the input register (pin scaling on the way
// in), then the result register (state update and percent), before it
// appears on result.
// Throughput: one item per cycle while result.ready keeps up with the output.
// Reset: all mode flags, the idle counter and the stored sample clear;
// registers return to 20 ticks, 3600 mV and 3700 mV. No result is pending.
// Stall: a held result keeps its register; the input register still takes
// one more item, then item.ready drops until result.ready returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module battery_monitor_sleep_timer
    import bms_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bms_item_if.sink     item,
    bms_result_if.source result,
    bms_cfg_if.sink      cfg
);

    cfg_t   cfg_val;
    logic   stage_valid;
    stage_t stage_item;
    logic   take;

    bms_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    bms_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    bms_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_val     (cfg_val),
        .stage_valid (stage_valid),
        .stage_item  (stage_item),
        .take        (take),
        .result      (result)
    );

endmodule

@@ sim/tb_battery_monitor_sleep_timer.sv @@
// ----------------------------------------------------------------------------
// tb_battery_monitor_sleep_timer
// Self-checking testbench for the battery supervisor and sleep timer.
//
// A behavioral copy of the supervisor predicts the status item for every
// accepted input item. The checker compares each result item field by field
// against the oldest prediction. Directed tests cover the low-mode
// hysteresis, threshold equality, the sleep timer and a lowered sleep limit.
// Random phases follow at several register settings, including both
// extremes, with random idling on both sides and one long result stall.
// A final back-to-back burst runs with the sleep limit at zero, then at its
// largest value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_battery_monitor_sleep_timer;
    import bms_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int MAX_WAIT         = 17;
    localparam int HOLD_CYCLES      = 300;
    localparam int STALL_LIMIT      = 2000;
    localparam int MAX_REPORTS      = 40;
    localparam int NUM_PHASES       = 6;
    localparam int ITEMS_PER_PHASE  = 250;
    localparam int LONG_RUN_SAMPLES = 120;

    logic clk;
    logic rst_n;

    bms_item_if   item_ch ();
    bms_result_if res_ch ();
    bms_cfg_if    cfg_ch ();

    battery_monitor_sleep_timer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // supervisor shadow state
    cfg_t              cur_cfg;
    logic              low_q;
    logic              sleep_q;
    logic              disp_q;
    logic [TICK_W-1:0] idle_q;
    logic [MV_W-1:0]   mv_q;
    logic [PCT_W-1:0]  pct_q;

    res_t status_q[$];

    int errors      = 0;
    int n_items     = 0;
    int n_results   = 0;
    int n_writes    = 0;
    int n_low       = 0;
    int n_restart   = 0;
    int n_sleep     = 0;
    int idle_cycles = 0;
    int send_burst  = 0;
    int recv_burst  = 0;
    bit hold_request = 1'b0;
    bit no_idle      = 1'b0;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic res_t next_status(input logic [OP_W-1:0] op,
                                         input logic [PIN_W-1:0] pin,
                                         input logic chg_n);
        res_t r;
        int   v;
        int   pct;
        r = '0;
        case (op)
            OP_SAMPLE:
            begin
                v = (int'(pin) * 21) / 10;
                if (!low_q && v <= int'(cur_cfg.low_threshold_mv))
                begin
                    low_q             = 1'b1;
                    sleep_q           = 1'b1;
                    disp_q            = 1'b0;
                    r.radio_force_off = 1'b1;
                end
                else if (low_q && v >= int'(cur_cfg.restore_threshold_mv))
                begin
                    low_q     = 1'b0;
                    sleep_q   = 1'b0;
                    disp_q    = 1'b0;
                    idle_q    = '0;
                    r.restart = 1'b1;
                end
                if (low_q || v < int'(cur_cfg.low_threshold_mv))
                    pct = 0;
                else
                begin
                    pct = (v - int'(cur_cfg.low_threshold_mv)) / 6;
                    if (pct > 100)
                        pct = 100;
                end
                mv_q  = MV_W'(v);
                pct_q = PCT_W'(pct);
                if (!r.restart && !sleep_q && !low_q)
                begin
                    if (idle_q != IDLE_MAX)
                        idle_q = idle_q + 1'b1;
                    if (idle_q == cur_cfg.sleep_ticks)
                    begin
                        sleep_q = 1'b1;
                        disp_q  = 1'b0;
                        n_sleep++;
                    end
                end
            end
            OP_REFRESH:
                idle_q = '0;
            OP_WAKE:
            begin
                if (!low_q)
                begin
                    sleep_q = 1'b0;
                    idle_q  = '0;
                    disp_q  = 1'b1;
                end
                else
                begin
                    r.display_flash = 1'b1;
                    disp_q          = 1'b0;
                end
            end
            default: ;
        endcase
        r.battery_mv      = mv_q;
        r.battery_percent = pct_q;
        r.low_mode        = low_q;
        r.sleeping        = sleep_q;
        r.display_enable  = disp_q;
        r.charging        = ~chg_n;
        return r;
    endfunction

    function automatic int draw_wait(inout int burst);
        if (no_idle)
            return 0;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            burst = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
        end
    endfunction

    function automatic logic [OP_W-1:0] rand_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return OP_SAMPLE;
        if (r < 75)
            return OP_REFRESH;
        if (r < 95)
            return OP_WAKE;
        return OP_UNUSED;
    endfunction

    // mostly pins that land near one of the two thresholds
    function automatic logic [PIN_W-1:0] rand_pin();
        int center;
        int pin;
        case ($urandom_range(0, 9))
            0, 1, 2:
                return PIN_W'($urandom_range(0, 4095));
            3:
                return $urandom_range(0, 1) ? '1 : '0;
            default:
            begin
                center = $urandom_range(0, 1) ? int'(cur_cfg.low_threshold_mv)
                                              : int'(cur_cfg.restore_threshold_mv);
                pin = center * 10 / 21 + int'($urandom_range(0, 16)) - 8;
                if (pin < 0)
                    pin = 0;
                if (pin > 4095)
                    pin = 4095;
                return PIN_W'(pin);
            end
        endcase
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [PIN_W-1:0] pin,
                             input logic chg_n);
        int   gap;
        res_t r;
        gap = draw_wait(send_burst);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.operation  <= op;
        item_ch.pin_mv     <= pin;
        item_ch.charging_n <= chg_n;
        do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
        r = next_status(op, pin, chg_n);
        status_q.push_back(r);
        n_items++;
        if (r.radio_force_off)
            n_low++;
        if (r.restart)
            n_restart++;
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (status_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_setting(input logic [TICK_W-1:0] ticks, input logic [TH_W-1:0] low_th,
                                 input logic [TH_W-1:0] rest_th);
        logic [IDX_W-1:0]  idx [3];
        logic [DATA_W-1:0] val [3];
        idx = '{REG_SLEEP_TICKS, REG_LOW_TH, REG_RESTORE_TH};
        val = '{DATA_W'(ticks), DATA_W'(low_th), DATA_W'(rest_th)};
        wait_drained();
        for (int k = 0; k < 3; k++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[k];
            cfg_ch.data  <= val[k];
            do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
            case (idx[k])
                REG_SLEEP_TICKS: cur_cfg.sleep_ticks          = val[k];
                REG_LOW_TH:      cur_cfg.low_threshold_mv     = val[k][TH_W-1:0];
                default:         cur_cfg.restore_threshold_mv = val[k][TH_W-1:0];
            endcase
            n_writes++;
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_item(OP_SAMPLE, 12'd0, 1'b1);      // zero pin enters low mode
        send_item(OP_UNUSED, 12'hFFF, 1'b0);
        send_item(OP_WAKE, 12'd0, 1'b1);        // low mode: flash only
        send_item(OP_SAMPLE, 12'hFFF, 1'b0);    // full scale recovers, percent clamps
        send_item(OP_REFRESH, 12'h555, 1'b1);
    endtask

    task automatic test_low_hysteresis();
        send_item(OP_SAMPLE, 12'd1800, 1'b1);
        send_item(OP_SAMPLE, 12'd1714, 1'b0);   // 3599 mV
        send_item(OP_SAMPLE, 12'd1740, 1'b1);   // inside the hysteresis band
        send_item(OP_WAKE, 12'd1740, 1'b0);
        send_item(OP_REFRESH, 12'd1740, 1'b1);
        send_item(OP_SAMPLE, 12'd1762, 1'b0);   // exactly 3700 mV
    endtask

    task automatic test_threshold_equality();
        apply_setting(16'd20, 13'd3601, 13'd3780);
        send_item(OP_SAMPLE, 12'd1715, 1'b1);   // equals low threshold
        send_item(OP_SAMPLE, 12'd1799, 1'b0);   // just under restore
        send_item(OP_SAMPLE, 12'd1800, 1'b1);   // equals restore threshold
    endtask

    task automatic test_sleep_timer();
        apply_setting(16'd3, LOW_TH_RST, RESTORE_TH_RST);
        send_item(OP_WAKE, 12'd2000, 1'b1);
        repeat (3) send_item(OP_SAMPLE, 12'd2000, 1'b0);
        send_item(OP_SAMPLE, 12'd2000, 1'b1);   // asleep, counter holds
        send_item(OP_WAKE, 12'd2000, 1'b0);
        repeat (2) send_item(OP_SAMPLE, 12'd2000, 1'b1);
        // counter passes a lowered limit without sleeping
        apply_setting(16'd1, LOW_TH_RST, RESTORE_TH_RST);
        send_item(OP_SAMPLE, 12'd2000, 1'b0);
        send_item(OP_REFRESH, 12'd2000, 1'b1);
        send_item(OP_SAMPLE, 12'd2000, 1'b0);
    endtask

    task automatic test_random_traffic();
        int low_th;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                    apply_setting(SLEEP_TICKS_RST, LOW_TH_RST, RESTORE_TH_RST);
                1:
                begin
                    low_th = int'($urandom_range(3000, 3800));
                    apply_setting(TICK_W'($urandom_range(1, 12)), TH_W'(low_th),
                                  TH_W'(low_th + int'($urandom_range(0, 300))));
                end
                2:
                    apply_setting('0, '0, '0);
                3:
                    apply_setting('1, '1, '1);
                4:
                    apply_setting(16'd1, TH_W'($urandom_range(0, 8191)),
                                  TH_W'($urandom_range(0, 8191)));
                default:
                begin
                    low_th = int'($urandom_range(2500, 4500));
                    apply_setting(TICK_W'($urandom_range(2, 40)), TH_W'(low_th),
                                  TH_W'(low_th + int'($urandom_range(0, 500))));
                end
            endcase
            if (p == 1)
                hold_request = 1'b1;
            repeat (ITEMS_PER_PHASE)
                send_item(rand_op(), rand_pin(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_never_sleep();
        apply_setting('0, LOW_TH_RST, RESTORE_TH_RST);
        no_idle = 1'b1;
        send_item(OP_SAMPLE, 12'hFFF, 1'b1);    // leaves low mode if still in it
        send_item(OP_WAKE, 12'd2000, 1'b0);
        // zero limit: the counter runs on without sleeping
        repeat (LONG_RUN_SAMPLES)
            send_item(OP_SAMPLE, 12'd2000, 1'($urandom_range(0, 1)));
        // largest limit stays out of reach
        apply_setting(IDLE_MAX, LOW_TH_RST, RESTORE_TH_RST);
        send_item(OP_SAMPLE, 12'd2000, 1'b1);
        send_item(OP_REFRESH, 12'd2000, 1'b0);
        no_idle = 1'b0;
    endtask

    initial
    begin : result_sink
        res_t want;
        int   stall;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            stall = draw_wait(recv_burst);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
            n_results++;
            if (status_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: unexpected result item, expected none, actual mv %0d",
                             $time, res_ch.battery_mv);
            end
            else
            begin
                want = status_q.pop_front();
                check_field("battery_mv", 16'(want.battery_mv), 16'(res_ch.battery_mv));
                check_field("battery_percent", 16'(want.battery_percent),
                            16'(res_ch.battery_percent));
                check_field("low_mode", 16'(want.low_mode), 16'(res_ch.low_mode));
                check_field("sleeping", 16'(want.sleeping), 16'(res_ch.sleeping));
                check_field("display_enable", 16'(want.display_enable),
                            16'(res_ch.display_enable));
                check_field("display_flash", 16'(want.display_flash),
                            16'(res_ch.display_flash));
                check_field("radio_force_off", 16'(want.radio_force_off),
                            16'(res_ch.radio_force_off));
                check_field("restart", 16'(want.restart), 16'(res_ch.restart));
                check_field("charging", 16'(want.charging), 16'(res_ch.charging));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: timeout, nothing moved for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.operation  <= OP_SAMPLE;
        item_ch.pin_mv     <= '0;
        item_ch.charging_n <= 1'b1;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_SLEEP_TICKS;
        cfg_ch.data        <= '0;
        cur_cfg = '{SLEEP_TICKS_RST, LOW_TH_RST, RESTORE_TH_RST};
        low_q   = 1'b0;
        sleep_q = 1'b0;
        disp_q  = 1'b0;
        idle_q  = '0;
        mv_q    = '0;
        pct_q   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_low_hysteresis();
        test_threshold_equality();
        test_sleep_timer();
        test_random_traffic();
        test_never_sleep();

        wait_drained();
        repeat (4) @(posedge clk);
        $display("Covered %0d items, %0d results, %0d register writes incl. both extremes",
                 n_items, n_results, n_writes);
        $display("Low-mode entries %0d, restarts %0d, timer sleeps %0d, mismatches %0d",
                 n_low, n_restart, n_sleep, errors);
        if (errors == 0 && status_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
